[rtl/core/unique_entry_list_with_compaction_top_defines.svh]
// Assertion macros shared by the entry list RTL.
`ifndef UNIQUE_ENTRY_LIST_WITH_COMPACTION_TOP_DEFINES_SVH
`define UNIQUE_ENTRY_LIST_WITH_COMPACTION_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define UELC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define UELC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/uelc_pkg.sv]
// Shared types and constants for the entry list.
`timescale 1ns / 1ps
package uelc_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam int OP_W      = 2;
	localparam int CHAPTER_W = 16;
	localparam int PAGE_W    = 16;
	localparam int INDEX_W   = 4;
	localparam int STAMP_W   = 32;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 5;

	// hit bits examined per search cycle
	localparam int GROUP_W   = 8;
	localparam int GROUP_LOG = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_DUP       = 3'd2,
		ST_BAD_INDEX = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_BUSY
	} state_t;

	typedef struct packed {
		logic [CHAPTER_W-1:0] chapter;
		logic [PAGE_W-1:0]    page;
		logic [STAMP_W-1:0]   stamp;
	} entry_t;

	typedef struct packed {
		logic                 cmp_en;
		logic                 write_en;
		logic                 shift_en;
		logic [CHAPTER_W-1:0] probe_chapter;
		logic [PAGE_W-1:0]    probe_page;
		entry_t               fill;
	} cell_ctrl_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

[rtl/core/uelc_cell.sv]
// One list position: stored entry, pair compare and shift from the upper neighbor.
`timescale 1ns / 1ps
module uelc_cell #(
	parameter int MAX_ENTRIES = uelc_pkg::MAX_ENTRIES_DEF,
	parameter int POS         = 0
) (
	input  logic                                 clk,
	input  uelc_pkg::cell_ctrl_t                 ctrl,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]     live_count,
	input  logic [uelc_pkg::INDEX_W-1:0]         rm_index,
	input  uelc_pkg::entry_t                     entry_next,
	output uelc_pkg::entry_t                     entry,
	output logic                                 hit
);
	import uelc_pkg::*;

	entry_t entry_q;
	logic   hit_q;
	logic   live;
	logic   here;
	logic   past_idx;

	assign live     = POS < int'(live_count);
	assign here     = POS == int'(live_count);
	assign past_idx = POS >= int'(rm_index);

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			hit_q <= live && (entry_q.chapter == ctrl.probe_chapter)
				&& (entry_q.page == ctrl.probe_page);
		end
		// append lands on the first free cell; remove pulls every cell at or above the hole
		if (ctrl.write_en && here) begin
			entry_q <= ctrl.fill;
		end else if (ctrl.shift_en && past_idx) begin
			entry_q <= entry_next;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

[rtl/core/uelc_scan.sv]
// Lowest-hit search over the cell row, one group of hit bits per cycle.
`timescale 1ns / 1ps
module uelc_scan #(
	parameter int MAX_ENTRIES = uelc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 run,
	input  logic [MAX_ENTRIES-1:0]               hits,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]     live_count,
	output uelc_pkg::scan_stat_t                 stat,
	output logic [$clog2(MAX_ENTRIES)-1:0]       pos
);
	import uelc_pkg::*;

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int IW   = $clog2(MAX_ENTRIES);
	localparam int NG   = (MAX_ENTRIES + GROUP_W - 1) / GROUP_W;
	localparam int PADW = NG * GROUP_W;
	localparam int PW   = $clog2(NG + 1);
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
	localparam int BW   = PW + GROUP_LOG;
	localparam int XW   = (BW > CW) ? BW : CW;

	logic [PADW-1:0]      hits_pad;
	logic [GROUP_W-1:0]   groups [NG];
	logic [GROUP_W-1:0]   grp;
	logic [PW-1:0]        ptr_q;
	logic                 found_q;
	logic [IW-1:0]        pos_q;
	logic [BW-1:0]        base;
	logic                 at_end;
	logic                 any;
	logic [GROUP_LOG-1:0] low;

	assign hits_pad = PADW'(hits);

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			groups[g] = hits_pad[g*GROUP_W +: GROUP_W];
		end
	end

	assign base   = {ptr_q, {GROUP_LOG{1'b0}}};
	assign at_end = XW'(base) >= XW'(live_count);
	assign grp    = groups[ptr_q[GW-1:0]];
	assign any    = |grp;

	always_comb begin
		low = '0;
		for (int b = GROUP_W - 1; b >= 0; b--) begin
			if (grp[b]) begin
				low = GROUP_LOG'(b);
			end
		end
	end

	assign stat.done  = found_q || at_end;
	assign stat.found = found_q;
	assign pos        = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else if (start) begin
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else if (run && !stat.done) begin
			ptr_q <= ptr_q + PW'(1);
			if (any) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run && !stat.done && any) begin
			pos_q <= IW'(base + BW'(low));
		end
	end

endmodule

[rtl/core/unique_entry_list_with_compaction_top.sv]
// Top level of the packed unique entry list: cell row, hit search and request control.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | to block  | in_valid / in_ready  | operation, chapter_number, page_number,
//          |           |                      | entry_index, time_stamp
//  out     | from block| out_valid / out_ready| status, match_index, entry_count
//
// Remove, clear and add on a full list finish in the busy state without a hit search.
// Add and find run the hit search: it walks the registered compare bits of the cell row
// eight cells per cycle and stops at the first hit or once it passes the live entries.
// One item is in work at a time; the next is taken once the result is in the output register.
// Reset empties the list and drops any pending result; stored entries are not cleared.
// A stalled output holds its result; a finished item waits until the held result is taken.
`timescale 1ns / 1ps
`include "unique_entry_list_with_compaction_top_defines.svh"
module unique_entry_list_with_compaction_top #(
	parameter int MAX_ENTRIES = uelc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [uelc_pkg::OP_W-1:0]         operation,
	input  logic [uelc_pkg::CHAPTER_W-1:0]    chapter_number,
	input  logic [uelc_pkg::PAGE_W-1:0]       page_number,
	input  logic [uelc_pkg::INDEX_W-1:0]      entry_index,
	input  logic [uelc_pkg::STAMP_W-1:0]      time_stamp,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [uelc_pkg::STATUS_W-1:0]     status,
	output logic [uelc_pkg::INDEX_W-1:0]      match_index,
	output logic [uelc_pkg::COUNT_W-1:0]      entry_count
);
	import uelc_pkg::*;

	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int IW  = $clog2(MAX_ENTRIES);
	localparam int XIW = (INDEX_W > CW) ? INDEX_W : CW;

	state_t                 state_q;
	state_t                 state_d;
	op_t                    op_q;
	logic [INDEX_W-1:0]     idx_q;
	entry_t                 fill_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_d;
	logic                   out_valid_q;
	status_t                status_q;
	logic [INDEX_W-1:0]     match_q;
	logic [COUNT_W-1:0]     ecount_q;

	logic                   accept;
	logic                   out_free;
	logic                   finish;
	logic                   commit;
	logic                   full;
	logic                   bad_idx;
	status_t                res_status;
	logic [IW-1:0]          res_match;
	logic                   wr;
	logic                   sh;

	cell_ctrl_t             ctrl;
	entry_t                 ent [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] hits;
	scan_stat_t             scan_stat;
	logic [IW-1:0]          pos;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign full     = count_q == CW'(MAX_ENTRIES);
	assign bad_idx  = XIW'(idx_q) >= XIW'(count_q);

	always_comb begin
		unique case (op_q)
			OP_ADD:    finish = full || scan_stat.done;
			OP_FIND:   finish = scan_stat.done;
			OP_REMOVE: finish = 1'b1;
			OP_CLEAR:  finish = 1'b1;
			default:   finish = 1'b1;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_BUSY;
				end
			end
			S_BUSY: begin
				if (finish && out_free) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		res_status = ST_OK;
		res_match  = '0;
		count_d    = count_q;
		wr         = 1'b0;
		sh         = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (scan_stat.found) begin
					res_status = ST_DUP;
					res_match  = pos;
				end else begin
					res_match = IW'(count_q);
					count_d   = count_q + CW'(1);
					wr        = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (bad_idx) begin
					res_status = ST_BAD_INDEX;
				end else begin
					count_d = count_q - CW'(1);
					sh      = 1'b1;
				end
			end
			OP_FIND: begin
				if (scan_stat.found) begin
					res_match = pos;
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: count_d = '0;
			default:  count_d = count_q;
		endcase
	end

	// compare on accept, write or shift on commit
	assign ctrl.cmp_en        = accept;
	assign ctrl.write_en      = commit && wr;
	assign ctrl.shift_en      = commit && sh;
	assign ctrl.probe_chapter = chapter_number;
	assign ctrl.probe_page    = page_number;
	assign ctrl.fill          = fill_q;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		entry_t nxt;
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign nxt = ent[i];
		end else begin : g_mid
			assign nxt = ent[i+1];
		end
		uelc_cell #(
			.MAX_ENTRIES (MAX_ENTRIES),
			.POS         (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.live_count (count_q),
			.rm_index   (idx_q),
			.entry_next (nxt),
			.entry      (ent[i]),
			.hit        (hits[i])
		);
	end

	uelc_scan #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.run        (state_q == S_BUSY),
		.hits       (hits),
		.live_count (count_q),
		.stat       (scan_stat),
		.pos        (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= op_t'(operation);
			idx_q        <= entry_index;
			fill_q.chapter <= chapter_number;
			fill_q.page    <= page_number;
			fill_q.stamp   <= time_stamp;
		end
		if (commit) begin
			status_q <= res_status;
			match_q  <= INDEX_W'(res_match);
			ecount_q <= COUNT_W'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_index = match_q;
	assign entry_count = ecount_q;

	`UELC_ASSERT_NEXT(a_one_item, accept, !in_ready, "item accepted while another is in work")
	`UELC_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES), "count past capacity")
	`UELC_ASSERT_NEXT(a_add_grows, commit && (op_q == OP_ADD) && (res_status == ST_OK),
		count_q == $past(count_q) + CW'(1), "successful add did not grow the list")
	`UELC_ASSERT_IMPL(a_hit_at_pos, commit && (op_q == OP_FIND) && scan_stat.found,
		hits[pos], "found position holds no hit")
	`UELC_ASSERT_NEXT(a_out_on_commit, commit, out_valid_q, "finished item not presented")

endmodule
